// File: rtl/spm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_pkg: shared types and constants of the shortest path matrix block
// Holds the cost encoding, operation codes, the load word and the controller
// states used by the top level and the cost memory.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int unsigned DIST_W = 10;
  localparam int unsigned FLD_W  = 4;

  // Cost that marks a missing edge or an unreachable vertex
  localparam logic [DIST_W-1:0] NO_EDGE = 10'd999;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_START = 1'b1;

  // One edge load word
  typedef struct packed {
    logic [FLD_W-1:0]  row;
    logic [FLD_W-1:0]  col;
    logic [DIST_W-1:0] weight;
  } load_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_RELAX,
    S_NEXT,
    S_OUT_RD,
    S_OUT_LD
  } state_e;

endpackage

// File: rtl/spm_cost_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_cost_mem: edge cost storage
// Single write, single read synchronous memory of edge costs. Loads outside
// the matrix are dropped and weights above the no-edge code are clamped.
// ----------------------------------------------------------------------------
module spm_cost_mem #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic                       clk_i,
  input  logic                       ld_en_i,
  input  spm_pkg::load_t             ld_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(MAX_NODES)-1:0] rd_row_i,
  input  logic [$clog2(MAX_NODES)-1:0] rd_col_i,
  output logic [spm_pkg::DIST_W-1:0] rd_data_o
);

  localparam int unsigned VW    = $clog2(MAX_NODES);
  localparam int unsigned AW    = 2 * VW;
  localparam int unsigned DEPTH = 2 ** AW;

  logic [spm_pkg::DIST_W-1:0] mem [DEPTH];

  logic [31:0]                row_ext;
  logic [31:0]                col_ext;
  logic                       in_range;
  logic [AW-1:0]              wr_addr;
  logic [spm_pkg::DIST_W-1:0] wr_data;

  // Drop loads outside the matrix, clamp oversized weights
  always_comb begin
    row_ext  = 32'(ld_i.row);
    col_ext  = 32'(ld_i.col);
    in_range = (row_ext < MAX_NODES) && (col_ext < MAX_NODES);
    wr_addr  = {row_ext[VW-1:0], col_ext[VW-1:0]};
    wr_data  = (ld_i.weight > spm_pkg::NO_EDGE) ? spm_pkg::NO_EDGE : ld_i.weight;
  end

  always_ff @(posedge clk_i) begin
    if (ld_en_i && in_range) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[{rd_row_i, rd_col_i}];
    end
  end

endmodule

// File: rtl/shortest_path_matrix_top.sv
`timescale 1ns / 1ps
// Single-source shortest paths over a stored cost matrix. A load word writes
// one edge cost. A start word runs the search with the vertex count n taken
// from the configuration register: the distance memory is set up for all n
// vertices, then up to n-1 rounds follow, in which the distance memory and
// the cost memory are swept one vertex per cycle, with the next round's pick
// found on the write-back path. Results then leave one word at a time: each
// is read from the distance memory and loaded into the output register once
// the output is free. The input is held off from a start word until its last
// result sits in the output register.
// ----------------------------------------------------------------------------
// shortest_path_matrix_top: Dijkstra shortest path engine
// Sequencer around a cost memory and a distance memory with read, relax and
// write back per vertex, followed by a result stream with a last flag.
// ----------------------------------------------------------------------------
module shortest_path_matrix_top #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [4:0]                 cfg_data_i,
  // input words
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [3:0]                 from_vertex_i,
  input  logic [3:0]                 to_vertex_i,
  input  logic [spm_pkg::DIST_W-1:0] edge_weight_i,
  input  logic [3:0]                 source_vertex_i,
  // result words
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [3:0]                 vertex_index_o,
  output logic [spm_pkg::DIST_W-1:0] distance_o,
  output logic                       reachable_o,
  output logic                       last_result_o
);

  localparam int unsigned VW = $clog2(MAX_NODES);
  localparam int unsigned NW = $clog2(MAX_NODES + 1);
  localparam int unsigned DW = spm_pkg::DIST_W;

  spm_pkg::state_e state_q, state_d;

  logic [4:0]    vcount_q;
  logic [NW-1:0] n_cnt;
  logic [VW-1:0] v_q, v_d;
  logic [VW-1:0] pick_q, pick_d;
  logic [DW-1:0] least_q, least_d;
  logic [VW-1:0] round_q, round_d;
  logic [3:0]    src_q, src_d;
  logic [DW-1:0] mn_q, mn_d;
  logic [VW-1:0] mp_q, mp_d;
  logic          wb_vld_q, wb_vld_d;
  logic [VW-1:0] wb_idx_q, wb_idx_d;
  logic          out_vld_q, out_vld_d;
  logic [3:0]    out_idx_q, out_idx_d;
  logic [DW-1:0] out_dist_q, out_dist_d;
  logic          out_reach_q, out_reach_d;
  logic          out_last_q, out_last_d;

  // distance memory: {done mark, distance}
  logic [DW:0]   dist_mem [MAX_NODES];
  logic [DW:0]   dist_rdata_q;
  logic          dist_rd_en;
  logic [VW-1:0] dist_rd_addr;
  logic          dist_we;
  logic [VW-1:0] dist_wa;
  logic [DW:0]   dist_wd;

  logic          cost_rd_en;
  logic [DW-1:0] cost_rdata;
  logic          load_en;
  spm_pkg::load_t load_word;

  logic          in_acc;
  logic          n_zero;
  logic          v_last;
  logic          src_ok;
  logic          start_ok;
  logic          out_free;
  logic [31:0]   src_ext;
  logic [31:0]   v_ext;

  logic          done_r;
  logic [DW-1:0] old_dist;
  logic [DW:0]   relax_sum;
  logic          relax_upd;
  logic [DW-1:0] new_dist;
  logic          cand;
  logic [DW-1:0] fin_least;
  logic [VW-1:0] fin_pick;
  logic          next_ok;
  logic          rd_reach;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == spm_pkg::S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  // Active vertex count, saturated to the matrix size
  assign n_cnt    = (32'(vcount_q) > MAX_NODES) ? NW'(MAX_NODES) : NW'(vcount_q);
  assign n_zero   = (n_cnt == '0);
  assign v_ext    = 32'(v_q);
  assign v_last   = ((v_ext + 32'd1) == 32'(n_cnt));
  assign src_ext  = 32'(src_q);
  assign src_ok   = (src_ext < 32'(n_cnt));
  assign start_ok = src_ok && (32'(n_cnt) > 32'd1);
  assign out_free = !out_vld_q || out_ready_i;

  // Relax the vertex whose words arrived from both memories
  always_comb begin
    done_r    = dist_rdata_q[DW] || (wb_idx_q == pick_q);
    old_dist  = dist_rdata_q[DW-1:0];
    relax_sum = {1'b0, least_q} + {1'b0, cost_rdata};
    relax_upd = !done_r && (cost_rdata != spm_pkg::NO_EDGE) && (relax_sum < {1'b0, old_dist});
    new_dist  = relax_upd ? relax_sum[DW-1:0] : old_dist;
    cand      = wb_vld_q && !done_r && (new_dist < mn_q);
    fin_least = cand ? new_dist : mn_q;
    fin_pick  = cand ? wb_idx_q : mp_q;
    next_ok   = (fin_least < spm_pkg::NO_EDGE) && ((32'(round_q) + 32'd2) < 32'(n_cnt));
    rd_reach  = (dist_rdata_q[DW-1:0] < spm_pkg::NO_EDGE);
  end

  // Edge loads go straight to the cost memory
  assign load_en       = in_acc && (op_i == spm_pkg::OP_LOAD);
  assign load_word.row    = from_vertex_i;
  assign load_word.col    = to_vertex_i;
  assign load_word.weight = edge_weight_i;

  spm_cost_mem #(
    .MAX_NODES(MAX_NODES)
  ) u_cost_mem (
    .clk_i    (clk_i),
    .ld_en_i  (load_en),
    .ld_i     (load_word),
    .rd_en_i  (cost_rd_en),
    .rd_row_i (pick_q),
    .rd_col_i (v_q),
    .rd_data_o(cost_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spm_pkg::S_IDLE: begin
        if (in_acc && (op_i == spm_pkg::OP_START)) begin
          state_d = spm_pkg::S_INIT;
        end
      end
      spm_pkg::S_INIT: begin
        if (n_zero) begin
          state_d = spm_pkg::S_IDLE;
        end else if (v_last) begin
          state_d = start_ok ? spm_pkg::S_RELAX : spm_pkg::S_OUT_RD;
        end
      end
      spm_pkg::S_RELAX: begin
        if (v_last) begin
          state_d = spm_pkg::S_NEXT;
        end
      end
      spm_pkg::S_NEXT: begin
        state_d = next_ok ? spm_pkg::S_RELAX : spm_pkg::S_OUT_RD;
      end
      spm_pkg::S_OUT_RD: begin
        if (out_free) begin
          state_d = spm_pkg::S_OUT_LD;
        end
      end
      spm_pkg::S_OUT_LD: begin
        state_d = v_last ? spm_pkg::S_IDLE : spm_pkg::S_OUT_RD;
      end
      default: state_d = spm_pkg::S_IDLE;
    endcase
  end

  // Datapath control and memory accesses
  always_comb begin
    v_d          = v_q;
    pick_d       = pick_q;
    least_d      = least_q;
    round_d      = round_q;
    src_d        = src_q;
    mn_d         = mn_q;
    mp_d         = mp_q;
    wb_vld_d     = 1'b0;
    wb_idx_d     = wb_idx_q;
    out_vld_d    = out_vld_q;
    out_idx_d    = out_idx_q;
    out_dist_d   = out_dist_q;
    out_reach_d  = out_reach_q;
    out_last_d   = out_last_q;
    dist_rd_en   = 1'b0;
    dist_rd_addr = v_q;
    dist_we      = 1'b0;
    dist_wa      = wb_idx_q;
    dist_wd      = {done_r, new_dist};
    cost_rd_en   = 1'b0;

    // drop the result word once taken
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    // write back the relaxed vertex and track the next pick
    if (wb_vld_q) begin
      dist_we = 1'b1;
      if (cand) begin
        mn_d = new_dist;
        mp_d = wb_idx_q;
      end
    end

    case (state_q)
      spm_pkg::S_IDLE: begin
        if (in_acc && (op_i == spm_pkg::OP_START)) begin
          v_d   = '0;
          src_d = source_vertex_i;
        end
      end
      spm_pkg::S_INIT: begin
        if (!n_zero) begin
          dist_we = 1'b1;
          dist_wa = v_q;
          dist_wd = {1'b0, (v_ext == src_ext) ? {DW{1'b0}} : spm_pkg::NO_EDGE};
          v_d     = v_q + VW'(1);
          if (v_last) begin
            v_d     = '0;
            pick_d  = src_ext[VW-1:0];
            least_d = '0;
            round_d = '0;
            mn_d    = spm_pkg::NO_EDGE;
          end
        end
      end
      spm_pkg::S_RELAX: begin
        dist_rd_en = 1'b1;
        cost_rd_en = 1'b1;
        wb_vld_d   = 1'b1;
        wb_idx_d   = v_q;
        v_d        = v_last ? '0 : v_q + VW'(1);
      end
      spm_pkg::S_NEXT: begin
        round_d = round_q + VW'(1);
        pick_d  = fin_pick;
        least_d = fin_least;
        mn_d    = spm_pkg::NO_EDGE;
        v_d     = '0;
      end
      spm_pkg::S_OUT_RD: begin
        if (out_free) begin
          dist_rd_en = 1'b1;
        end
      end
      spm_pkg::S_OUT_LD: begin
        out_vld_d   = 1'b1;
        out_idx_d   = v_ext[3:0];
        out_reach_d = rd_reach;
        out_dist_d  = rd_reach ? dist_rdata_q[DW-1:0] : '0;
        out_last_d  = v_last;
        v_d         = v_last ? '0 : v_q + VW'(1);
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= spm_pkg::S_IDLE;
      vcount_q  <= 5'd16;
      v_q       <= '0;
      round_q   <= '0;
      wb_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      v_q       <= v_d;
      round_q   <= round_d;
      wb_vld_q  <= wb_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vcount_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pick_q      <= pick_d;
    least_q     <= least_d;
    src_q       <= src_d;
    mn_q        <= mn_d;
    mp_q        <= mp_d;
    wb_idx_q    <= wb_idx_d;
    out_idx_q   <= out_idx_d;
    out_dist_q  <= out_dist_d;
    out_reach_q <= out_reach_d;
    out_last_q  <= out_last_d;
  end

  // Distance memory
  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dist_rd_en) begin
      dist_rdata_q <= dist_mem[dist_rd_addr];
    end
  end

  assign out_valid_o    = out_vld_q;
  assign vertex_index_o = out_idx_q;
  assign distance_o     = out_dist_q;
  assign reachable_o    = out_reach_q;
  assign last_result_o  = out_last_q;

endmodule

// File: rtl/spm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_checker: port level checks of the shortest path matrix block
// Watches the handshakes and result words of the top level; bound below.
// ----------------------------------------------------------------------------
module spm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       op_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [3:0]                 vertex_index_o,
  input logic [spm_pkg::DIST_W-1:0] distance_o,
  input logic                       reachable_o,
  input logic                       last_result_o
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o)
      && $stable(vertex_index_o) && $stable(last_result_o))
    else $error("result word changed while stalled");

  // Unreachable vertices report zero, reachable ones stay below no-edge
  a_dist_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reachable_o ? (distance_o < spm_pkg::NO_EDGE) : (distance_o == '0)))
    else $error("distance does not match reachable flag");

  // The input is not ready right after a start word is taken
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == spm_pkg::OP_START) |=> !in_ready_o)
    else $error("input taken right after a start word");

  // Nothing follows the last result of a search at once
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_result_o |=> !out_valid_o)
    else $error("result word right after the last one");

endmodule

bind shortest_path_matrix_top spm_checker u_spm_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the shortest path matrix block
// Loads edge costs and starts searches over a sweep of vertex counts. A
// driver feeds words from a queue and mirrors the block on every accepted
// word. A monitor compares each result word with the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;
  import spm_pkg::*;

  localparam int unsigned NODES         = 16;
  localparam int unsigned HALF_PERIOD   = 6;
  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned HOLD_CYCLES   = 800;
  localparam int unsigned PHASE_WORDS   = 6;
  localparam int unsigned CALM_FROM     = 2000;
  localparam int unsigned CALM_TO       = 5000;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // One input word as it sits on the ports
  typedef struct packed {
    logic              op;
    logic [3:0]        row;
    logic [3:0]        col;
    logic [DIST_W-1:0] weight;
    logic [3:0]        source;
  } path_word_t;

  // One result word
  typedef struct packed {
    logic [3:0]        vertex;
    logic [DIST_W-1:0] dist_val;
    logic              reach;
    logic              last;
  } dist_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [4:0]        cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  path_word_t        drv_word = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [3:0]        vertex_index_o;
  logic [DIST_W-1:0] distance_o;
  logic              reachable_o;
  logic              last_result_o;

  // Mirror of the block: cost memory and vertex count register
  logic [DIST_W-1:0] cost_q [NODES][NODES];
  int unsigned       cfg_vertices = 16;

  path_word_t        pending_words [$];
  dist_word_t        expected_dists [$];
  dist_word_t        head_dist;

  // Stimulus side: which cost entries hold a written value
  bit                loaded [NODES][NODES];
  int unsigned       phase_nodes;

  int unsigned       words_queued = 0;
  int unsigned       words_accepted = 0;
  int unsigned       loads_accepted = 0;
  int unsigned       searches_accepted = 0;
  int unsigned       results_checked = 0;
  int unsigned       settings_written = 0;
  int unsigned       mismatches = 0;
  int unsigned       cycle_count = 0;
  int unsigned       hold_left = 0;
  bit                hold_used = 1'b0;

  wire calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

  shortest_path_matrix_top #(
    .MAX_NODES(NODES)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (drv_word.op),
    .from_vertex_i  (drv_word.row),
    .to_vertex_i    (drv_word.col),
    .edge_weight_i  (drv_word.weight),
    .source_vertex_i(drv_word.source),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .vertex_index_o (vertex_index_o),
    .distance_o     (distance_o),
    .reachable_o    (reachable_o),
    .last_result_o  (last_result_o)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Store a cost, or run the search and queue one distance word per vertex
  task automatic predict_distances(input path_word_t w);
    int unsigned n, v, rnd, pick, least, sum;
    bit          found;
    int unsigned best_dist [NODES];
    bit          visited [NODES];
    dist_word_t  res;
    if (w.op == OP_LOAD) begin
      cost_q[w.row][w.col] = (w.weight > NO_EDGE) ? NO_EDGE : w.weight;
      return;
    end
    n = (cfg_vertices > NODES) ? NODES : cfg_vertices;
    for (v = 0; v < n; v++) begin
      best_dist[v] = NO_EDGE;
      visited[v] = 1'b0;
    end
    if (w.source < n) begin
      best_dist[w.source] = 0;
      for (rnd = 0; rnd + 1 < n; rnd++) begin
        found = 1'b0;
        least = NO_EDGE;
        pick = 0;
        // pick the closest unvisited vertex, lowest index on a tie
        for (v = 0; v < n; v++) begin
          if (!visited[v] && best_dist[v] < least) begin
            least = best_dist[v];
            pick = v;
            found = 1'b1;
          end
        end
        if (!found) break;
        visited[pick] = 1'b1;
        // relax; sums at or above the no-edge cost never land
        for (v = 0; v < n; v++) begin
          sum = least + cost_q[pick][v];
          if (!visited[v] && cost_q[pick][v] != NO_EDGE && sum < best_dist[v])
            best_dist[v] = sum;
        end
      end
    end
    for (v = 0; v < n; v++) begin
      res.vertex   = 4'(v);
      res.reach    = (w.source < n) && (best_dist[v] < NO_EDGE);
      res.dist_val = res.reach ? DIST_W'(best_dist[v]) : '0;
      res.last     = (v + 1 == n);
      expected_dists.push_back(res);
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
               exp_val, act_val);
      mismatches++;
    end
  endtask

  // Driver: mirror each accepted word, then offer the next one or idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_distances(drv_word);
        if (drv_word.op == OP_START) searches_accepted++;
        else loads_accepted++;
        words_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
          drv_word <= pending_words.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_dists.size() == 0) begin
          $display("%0t: result for vertex %0d arrived with none expected", $time,
                   vertex_index_o);
          mismatches++;
        end else begin
          head_dist = expected_dists.pop_front();
          check_field("vertex_index", head_dist.vertex, vertex_index_o);
          check_field("distance", head_dist.dist_val, distance_o);
          check_field("reachable", head_dist.reach, reachable_o);
          check_field("last_result", head_dist.last, last_result_o);
          results_checked++;
        end
      end
      out_ready_i <= (hold_left == 0) && (calm || $urandom_range(99) >= 33);
    end
  end

  // Hold the output off once, right after a search starts, so the input backs up
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && rst_ni && in_valid_i && in_ready_o &&
                 drv_word.op == OP_START && cfg_vertices >= 2) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d results still due", $time,
               expected_dists.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [DIST_W-1:0] pick_weight();
    case ($urandom_range(9))
      0, 1, 2, 3: return DIST_W'($urandom_range(60));
      4, 5:       return NO_EDGE;
      6:          return DIST_W'($urandom_range(1023, 1000));
      default:    return DIST_W'($urandom_range(998));
    endcase
  endfunction

  task automatic push_load(input int unsigned r, input int unsigned c,
                           input int unsigned w);
    path_word_t word;
    word.op     = OP_LOAD;
    word.row    = 4'(r);
    word.col    = 4'(c);
    word.weight = DIST_W'(w);
    word.source = 4'($urandom_range(15));
    loaded[r][c] = 1'b1;
    pending_words.push_back(word);
    words_queued++;
  endtask

  // Fill every unwritten cost among the vertices in use, then start
  task automatic push_search(input int unsigned src);
    path_word_t word;
    for (int unsigned r = 0; r < phase_nodes; r++)
      for (int unsigned c = 0; c < phase_nodes; c++)
        if (!loaded[r][c]) push_load(r, c, pick_weight());
    word.op     = OP_START;
    word.row    = 4'($urandom_range(15));
    word.col    = 4'($urandom_range(15));
    word.weight = DIST_W'($urandom_range(1023));
    word.source = 4'(src);
    pending_words.push_back(word);
    words_queued++;
  endtask

  // Wait until every word is taken and every result is back, then settle
  task automatic wait_drained();
    while (words_accepted != words_queued || expected_dists.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_vertex_count(input logic [4:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_vertices = value;
    phase_nodes = (value > NODES) ? NODES : value;
    settings_written++;
  endtask

  // Random phase: loads biased into the graph in use, searches mixed in
  task automatic run_phase(input logic [4:0] value);
    int unsigned r, c;
    set_vertex_count(value);
    for (int unsigned k = 0; k < PHASE_WORDS; k++) begin
      if ($urandom_range(3) == 0) begin
        if (phase_nodes != 0 && $urandom_range(4) != 0)
          push_search($urandom_range(phase_nodes - 1));
        else
          push_search($urandom_range(15));
      end else begin
        if (phase_nodes != 0 && $urandom_range(9) < 7) begin
          r = $urandom_range(phase_nodes - 1);
          c = $urandom_range(phase_nodes - 1);
        end else begin
          r = $urandom_range(15);
          c = $urandom_range(15);
        end
        push_load(r, c, pick_weight());
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: four vertices with oversized costs, sums that reach the
    // no-edge cost, zero-cost ties and far corners
    set_vertex_count(5'd4);
    push_load(0, 1, 500);
    push_load(0, 2, 20);
    push_load(0, 3, 1023);
    push_load(1, 2, 7);
    push_load(1, 3, 499);
    push_load(2, 3, 998);
    push_load(3, 0, 0);
    push_load(3, 1, 0);
    push_load(3, 2, 0);
    push_load(15, 15, 1023);
    push_load(15, 0, 0);
    for (int unsigned r = 0; r < 4; r++)
      for (int unsigned c = 0; c < 4; c++)
        if (!loaded[r][c]) push_load(r, c, NO_EDGE);
    push_search(0);
    push_search(3);
    push_search(4);
    push_search(15);
    wait_drained();

    // Sweep the vertex count through its extremes and saturation
    run_phase(5'd1);
    run_phase(5'd0);
    run_phase(5'd3);
    run_phase(5'd16);
    run_phase(5'd2);
    run_phase(5'd31);
    run_phase(5'd6);
    run_phase(5'd17);
    run_phase(5'd5);

    $display("Covered %0d edge loads and %0d searches over %0d vertex count settings",
             loads_accepted, searches_accepted, settings_written);
    $display("Checked %0d distance results, %0d mismatches", results_checked,
             mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
